// File: rtl/mmrs_pkg.sv
// shared constants and types for the row-streaming matrix multiply core
package mmrs_pkg;

    localparam int MAX_INNER  = 16;
    localparam int MAX_COLS   = 16;

    localparam int ELEM_W     = 16;
    localparam int PROD_W     = 2 * ELEM_W;
    localparam int ACC_W      = 40;
    localparam int ROW_W      = 16;
    localparam int DIM_W      = 5;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int INNER_W    = $clog2(MAX_INNER);
    localparam int K_CNT_W    = $clog2(MAX_INNER + 1);
    localparam int N_CNT_W    = $clog2(MAX_COLS + 1);
    localparam int B_DEPTH    = MAX_INNER * MAX_COLS;
    localparam int B_ADDR_W   = $clog2(B_DEPTH);
    localparam int KN_W       = $clog2(B_DEPTH + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_M  = 2'd0,
        CFG_INNER_K = 2'd1,
        CFG_COLS_N  = 2'd2
    } t_cfg_idx;

    localparam logic FUNC_LOAD_B   = 1'b0;
    localparam logic FUNC_STREAM_A = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT_RD,
        ST_EMIT_WAIT
    } t_state;

endpackage

// File: rtl/matrix_multiply_row_stream_core.sv
// Streaming matrix multiply: B held in a memory, A rows streamed, one result row per A row
//
// B is loaded first, one element per request in row-major order; a new load can be
// taken right after the last. An A element then runs one multiply-add per cycle, one
// column after another, through the single-ported B store and the accumulator memory,
// followed by a drain of the multiply and write-back stages. The A element that
// closes a row then reads the cols_n results back out of the accumulator memory one
// at a time, each waiting while the output side stalls. The last result may wait in the
// output register while the next request is taken. A configuration write
// to rows_m, inner_k or cols_n restarts B loading and the A stream at row 0, column 0
// with cleared accumulators. There is no clearing pass after reset; B entries read
// before being written are undefined.
module matrix_multiply_row_stream_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_func,
    input  logic signed [mmrs_pkg::ELEM_W-1:0]   i_element_value,

    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [mmrs_pkg::ACC_W-1:0]    o_product_value,
    output logic        [mmrs_pkg::ROW_W-1:0]    o_result_row,
    output logic        [mmrs_pkg::COL_W-1:0]    o_result_col,
    output logic                                 o_row_last,
    output logic                                 o_matrix_last,

    input  logic                                 i_cfg_we,
    input  logic        [mmrs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic        [mmrs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mmrs_pkg::*;

    // configuration
    logic [ROW_W-1:0]       r_rows_m;
    logic [DIM_W-1:0]       r_inner_k;
    logic [DIM_W-1:0]       r_cols_n;
    logic                   cfg_hit;

    logic [K_CNT_W-1:0]     eff_k;
    logic [N_CNT_W-1:0]     eff_n;
    logic [ROW_W-1:0]       eff_m;
    logic [KN_W-1:0]        kn;
    logic [INNER_W-1:0]     k_last;
    logic [COL_W-1:0]       n_last;
    logic [ROW_W-1:0]       m_last;

    // control
    t_state                 r_state, n_state;
    logic                   in_acc, b_we, a_acc, mac_issue, emit_rd, emit_load, slot_free;
    logic                   col_last, a_row_end, drained;

    logic [KN_W-1:0]        r_b_pos;
    logic [INNER_W-1:0]     r_a_pos;
    logic [B_ADDR_W-1:0]    r_a_base;
    logic [B_ADDR_W-1:0]    r_cur_base;
    logic                   r_row_end;
    logic [ROW_W-1:0]       r_row;
    logic [COL_W-1:0]       r_j;
    logic signed [ELEM_W-1:0] r_a_elem;

    // multiply-add pipeline
    logic                   r_s1_v, r_s2_v;
    logic [COL_W-1:0]       r_s1_j, r_s2_j;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  acc_sum;
    logic signed [ACC_W-1:0]  acc_old;

    // memories
    logic signed [ELEM_W-1:0] b_mem [B_DEPTH];
    logic signed [ELEM_W-1:0] r_b_q;
    logic [B_ADDR_W-1:0]    b_raddr;

    logic signed [ACC_W-1:0]  acc_mem [MAX_COLS];
    logic signed [ACC_W-1:0]  r_acc_q;
    logic                   r_acc_rv;
    logic [MAX_COLS-1:0]    r_acc_valid;
    logic                   acc_re;
    logic [COL_W-1:0]       acc_raddr;

    // output register
    logic                   r_o_valid;
    logic signed [ACC_W-1:0] r_o_value;
    logic [ROW_W-1:0]       r_o_row;
    logic [COL_W-1:0]       r_o_col;
    logic                   r_o_row_last;
    logic                   r_o_matrix_last;

    // effective dimensions
    always_comb begin
        if (r_inner_k == '0) begin
            eff_k = K_CNT_W'(1);
        end else if (int'(r_inner_k) > MAX_INNER) begin
            eff_k = K_CNT_W'(MAX_INNER);
        end else begin
            eff_k = K_CNT_W'(r_inner_k);
        end
        if (r_cols_n == '0) begin
            eff_n = N_CNT_W'(1);
        end else if (int'(r_cols_n) > MAX_COLS) begin
            eff_n = N_CNT_W'(MAX_COLS);
        end else begin
            eff_n = N_CNT_W'(r_cols_n);
        end
        eff_m  = (r_rows_m == '0) ? ROW_W'(1) : r_rows_m;
        kn     = KN_W'(eff_k) * KN_W'(eff_n);
        k_last = INNER_W'(eff_k - K_CNT_W'(1));
        n_last = COL_W'(eff_n - N_CNT_W'(1));
        m_last = eff_m - ROW_W'(1);
    end

    always_comb begin
        unique case (i_cfg_index)
            CFG_ROWS_M, CFG_INNER_K, CFG_COLS_N: cfg_hit = i_cfg_we;
            default:                             cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_m  <= ROW_W'(1);
            r_inner_k <= DIM_W'(1);
            r_cols_n  <= DIM_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROWS_M:  r_rows_m  <= i_cfg_data[ROW_W-1:0];
                CFG_INNER_K: r_inner_k <= i_cfg_data[DIM_W-1:0];
                CFG_COLS_N:  r_cols_n  <= i_cfg_data[DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign slot_free  = !r_o_valid || !i_out_stall;
    assign col_last   = (r_j == n_last);
    assign a_row_end  = (r_a_pos == k_last);
    assign drained    = !r_s1_v && !r_s2_v;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && i_func == FUNC_STREAM_A) n_state = ST_MAC;
            end
            ST_MAC: begin
                if (col_last) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (drained) n_state = r_row_end ? ST_EMIT_RD : ST_IDLE;
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT: begin
                if (slot_free) n_state = col_last ? ST_IDLE : ST_EMIT_RD;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        b_we      = 1'b0;
        a_acc     = 1'b0;
        mac_issue = 1'b0;
        emit_rd   = 1'b0;
        emit_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                b_we  = in_acc && (i_func == FUNC_LOAD_B);
                a_acc = in_acc && (i_func == FUNC_STREAM_A);
            end
            ST_MAC:       mac_issue = 1'b1;
            ST_DRAIN: begin
            end
            ST_EMIT_RD:   emit_rd   = 1'b1;
            ST_EMIT_WAIT: emit_load = slot_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // positions and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_pos   <= '0;
            r_a_pos   <= '0;
            r_a_base  <= '0;
            r_row     <= '0;
            r_j       <= '0;
            r_row_end <= 1'b0;
        end else if (cfg_hit) begin
            r_b_pos   <= '0;
            r_a_pos   <= '0;
            r_a_base  <= '0;
            r_row     <= '0;
            r_j       <= '0;
            r_row_end <= 1'b0;
        end else begin
            if (b_we) begin
                r_b_pos <= (r_b_pos + KN_W'(1) == kn) ? '0 : r_b_pos + KN_W'(1);
            end
            if (a_acc) begin
                r_row_end <= a_row_end;
                r_a_pos   <= a_row_end ? '0 : r_a_pos + INNER_W'(1);
                r_a_base  <= a_row_end ? '0 : r_a_base + B_ADDR_W'(eff_n);
            end
            if (a_acc || r_state == ST_DRAIN) begin
                r_j <= '0;
            end else if (mac_issue || emit_load) begin
                r_j <= r_j + COL_W'(1);
            end
            if (emit_load && col_last) begin
                r_row <= (r_row == m_last) ? '0 : r_row + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_acc) begin
            r_a_elem   <= i_element_value;
            r_cur_base <= r_a_base;
        end
    end

    // B store: written on loads, read one column per cycle while multiplying
    assign b_raddr = r_cur_base + B_ADDR_W'(r_j);

    always_ff @(posedge i_clk) begin
        if (b_we) b_mem[r_b_pos[B_ADDR_W-1:0]] <= i_element_value;
        if (mac_issue) r_b_q <= b_mem[b_raddr];
    end

    // pipeline: issue, multiply (accumulator read alongside), add and write back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= mac_issue;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_j <= r_j;
        r_s2_j <= r_s1_j;
        r_prod <= r_a_elem * r_b_q;
    end

    assign acc_old = r_acc_rv ? r_acc_q : '0;
    assign acc_sum = acc_old + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    // accumulator memory: one read port shared by the multiply stage and the result read-out
    assign acc_re    = r_s1_v || emit_rd;
    assign acc_raddr = emit_rd ? r_j : r_s1_j;

    always_ff @(posedge i_clk) begin
        if (r_s2_v) acc_mem[r_s2_j] <= acc_sum;
        if (acc_re) begin
            r_acc_q  <= acc_mem[acc_raddr];
            r_acc_rv <= r_acc_valid[acc_raddr];
        end
    end

    // an entry without its valid bit reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_acc_valid <= '0;
        end else begin
            if (r_s2_v) r_acc_valid[r_s2_j] <= 1'b1;
            if (emit_load) r_acc_valid[r_j] <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (emit_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            r_o_value       <= acc_old;
            r_o_row         <= r_row;
            r_o_col         <= r_j;
            r_o_row_last    <= col_last;
            r_o_matrix_last <= col_last && (r_row == m_last);
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_product_value = r_o_value;
    assign o_result_row    = r_o_row;
    assign o_result_col    = r_o_col;
    assign o_row_last      = r_o_row_last;
    assign o_matrix_last   = r_o_matrix_last;

    // write-back and multiply-stage read never touch the same accumulator
    a_acc_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && r_s2_v) |-> (r_s1_j != r_s2_j))
        else $error("accumulator read and write collide");

    // a new request is only taken once the pipeline is empty
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> (!r_s1_v && !r_s2_v))
        else $error("request taken while multiply pipeline busy");

    // a result is never loaded over one that is still stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_load |-> !(r_o_valid && i_out_stall))
        else $error("pending result overwritten");

    // load and inner positions stay inside the configured matrix
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_pos < kn) && (K_CNT_W'(r_a_pos) < eff_k))
        else $error("load or inner position out of range");

endmodule
